// File: rtl/core/rocmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational order compare package
// Result codes shared by the result channel interface and the compare core.
// ----------------------------------------------------------------------------
package rocmp_pkg;

	typedef enum logic [1:0] {
		ORDER_LESS    = 2'd0,
		ORDER_EQUAL   = 2'd1,
		ORDER_GREATER = 2'd2
	} order_t;

endpackage

// File: rtl/core/rocmp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational order compare channels
// Operand channel (two fractions) and result channel (order code),
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface rocmp_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] left_num;
	logic        [VALUE_WIDTH-2:0] left_den;
	logic signed [VALUE_WIDTH-1:0] right_num;
	logic        [VALUE_WIDTH-2:0] right_den;

	modport source (
		output valid, left_num, left_den, right_num, right_den,
		input  ready
	);
	modport sink (
		input  valid, left_num, left_den, right_num, right_den,
		output ready
	);
endinterface

interface rocmp_out_if
	import rocmp_pkg::*;
();
	logic   valid;
	logic   ready;
	order_t order_code;

	modport source (
		output valid, order_code,
		input  ready
	);
	modport sink (
		input  valid, order_code,
		output ready
	);
endinterface

// File: rtl/core/rational_order_compare_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational order compare unit
// Exact order of two fractions; zero denominators are signed infinities.
// ----------------------------------------------------------------------------
// Sequence: finite nonzero fractions of equal sign go through setup and run;
//   all other pairs go from idle straight to finish. Operands are accepted
//   only in idle, so a new pair waits until the last result is loaded. The
//   shared adder steps once per denominator bit to form |left_num|*right_den -
//   |right_num|*left_den; a held result stalls finish.
// Reset: asynchronous; sequencer returns to idle and the result register
//   is emptied.
// ----------------------------------------------------------------------------
module rational_order_compare_unit
	import rocmp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rocmp_in_if.sink     operands,
	rocmp_out_if.source  result
);

	localparam int ACC_W = 2 * VALUE_WIDTH;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int DEN_W = VALUE_WIDTH - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	order_t             out_code_q;
	logic               special_q;
	order_t             code_q;
	logic               neg_q;

	logic [VALUE_WIDTH-1:0] lm_q;
	logic signed [VALUE_WIDTH:0] nrm_q;
	logic signed [VALUE_WIDTH:0] diff_q;
	logic [DEN_W-1:0]       ld_q;
	logic [DEN_W-1:0]       rd_q;
	logic signed [ACC_W-1:0] acc_q;

	logic accept;
	logic out_free;
	logic l_neg, r_neg, l_zero, r_zero, ld_zero, rd_zero;
	logic [VALUE_WIDTH-1:0] l_mag, r_mag;
	logic signed [1:0] ls, rs, lv, rv, ca, cb;
	logic   special_d;
	order_t code_d;
	logic signed [ACC_W-1:0] add_a, add_b, add_sum;
	order_t acc_code, final_code;

	assign accept   = operands.valid && operands.ready;
	assign out_free = !out_valid_q || result.ready;

	assign operands.ready    = (state_q == ST_IDLE);
	assign result.valid      = out_valid_q;
	assign result.order_code = out_code_q;

	// operand split and special cases
	always_comb begin
		l_neg   = operands.left_num[VALUE_WIDTH-1];
		r_neg   = operands.right_num[VALUE_WIDTH-1];
		l_zero  = (operands.left_num == '0);
		r_zero  = (operands.right_num == '0);
		ld_zero = (operands.left_den == '0);
		rd_zero = (operands.right_den == '0);
		l_mag   = l_neg ? (~operands.left_num + 1'b1) : operands.left_num;
		r_mag   = r_neg ? (~operands.right_num + 1'b1) : operands.right_num;
		ls      = l_neg ? -2'sd1 : (l_zero ? 2'sd0 : 2'sd1);
		rs      = r_neg ? -2'sd1 : (r_zero ? 2'sd0 : 2'sd1);
		lv      = ld_zero ? (l_neg ? -2'sd1 : 2'sd1) : 2'sd0;
		rv      = rd_zero ? (r_neg ? -2'sd1 : 2'sd1) : 2'sd0;
		special_d = 1'b1;
		if (ld_zero || rd_zero) begin
			ca = lv;
			cb = rv;
		end else begin
			ca = ls;
			cb = rs;
			if (ls == rs && ls != 2'sd0) begin
				special_d = 1'b0;
			end
		end
		if (ca < cb) begin
			code_d = ORDER_LESS;
		end else if (ca > cb) begin
			code_d = ORDER_GREATER;
		end else begin
			code_d = ORDER_EQUAL;
		end
	end

	// shared adder
	always_comb begin
		if (state_q == ST_SETUP) begin
			add_a = ACC_W'(lm_q);
			add_b = ACC_W'(nrm_q);
		end else begin
			add_a = acc_q <<< 1;
			unique case ({rd_q[DEN_W-1], ld_q[DEN_W-1]})
				2'b10:   add_b = ACC_W'(lm_q);
				2'b01:   add_b = ACC_W'(nrm_q);
				2'b11:   add_b = ACC_W'(diff_q);
				default: add_b = '0;
			endcase
		end
		add_sum = add_a + add_b;
	end

	always_comb begin
		if (acc_q == '0) begin
			acc_code = ORDER_EQUAL;
		end else if (acc_q[ACC_W-1] ^ neg_q) begin
			acc_code = ORDER_LESS;
		end else begin
			acc_code = ORDER_GREATER;
		end
		final_code = special_q ? code_q : acc_code;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= ORDER_EQUAL;
		end else begin
			if (out_valid_q && result.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= special_d ? ST_FINISH : ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q   <= CNT_W'(VALUE_WIDTH - 2);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_code_q  <= final_code;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			special_q <= special_d;
			code_q    <= code_d;
			neg_q     <= l_neg;
			lm_q      <= l_mag;
			nrm_q     <= -$signed({1'b0, r_mag});
			ld_q      <= operands.left_den;
			rd_q      <= operands.right_den;
		end
		if (state_q == ST_SETUP) begin
			diff_q <= add_sum[VALUE_WIDTH:0];
			acc_q  <= '0;
		end
		if (state_q == ST_RUN) begin
			acc_q <= add_sum;
			ld_q  <= ld_q << 1;
			rd_q  <= rd_q << 1;
		end
	end

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result register loaded outside finish");

	a_run_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q != '0) |=>
			(state_q == ST_RUN && cnt_q == $past(cnt_q) - 1'b1))
		else $error("iteration counter out of step");

	a_setup_enters_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |=> (state_q == ST_RUN))
		else $error("setup did not start iterations");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && !result.ready) |=>
			(state_q == ST_FINISH && out_valid_q))
		else $error("pending result overwritten");

endmodule

// File: tb/sv/tb_rational_order_compare_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational order compare unit testbench
// Sends fraction pairs through the operand channel with random idle gaps and
// result back-pressure, predicts each order code from the cross-product sign
// and the signed-infinity rules, and checks every result in arrival order.
// ----------------------------------------------------------------------------
module tb_rational_order_compare_unit;
	import rocmp_pkg::*;

	localparam int VW           = 32;
	localparam int DW           = VW - 1;
	localparam int RANDOM_ITEMS = 1850;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_LEN     = 300;
	localparam int HOLD_AT      = 600;
	localparam int DRAIN_CYCLES = 2 * VW + 16;

	localparam logic signed [VW-1:0] NUM_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] NUM_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic        [VW-2:0] DEN_MAX = '1;

	class order_tracker;
		order_t pending_orders[$];
		int     checked;
		int     failures;
		int     inf_items;
		int     seen_codes[3];

		function int rank_order(longint a, longint b);
			return (a < b) ? ORDER_LESS : ((a > b) ? ORDER_GREATER : ORDER_EQUAL);
		endfunction

		function order_t fraction_order(logic signed [VW-1:0] ln, logic [VW-2:0] ld,
				logic signed [VW-1:0] rn, logic [VW-2:0] rd);
			longint lnum, lden, rnum, rden, lrank, rrank;
			lnum = ln;
			lden = ld;
			rnum = rn;
			rden = rd;
			if (ld == 0 || rd == 0) begin
				// zero denominator: signed infinity, zero numerator counts as plus
				lrank = (ld != 0) ? 0 : ((lnum < 0) ? -1 : 1);
				rrank = (rd != 0) ? 0 : ((rnum < 0) ? -1 : 1);
				return order_t'(rank_order(lrank, rrank));
			end
			return order_t'(rank_order(lnum * rden, rnum * lden));
		endfunction

		function void note_operands(logic signed [VW-1:0] ln, logic [VW-2:0] ld,
				logic signed [VW-1:0] rn, logic [VW-2:0] rd);
			if (ld == 0 || rd == 0)
				inf_items++;
			pending_orders.push_back(fraction_order(ln, ld, rn, rd));
		endfunction

		function void check_order(order_t got);
			order_t want;
			if (pending_orders.size() == 0) begin
				if (failures < 10)
					$display("[%0t] unexpected result, order code %0d", $time, got);
				failures++;
				return;
			end
			want = pending_orders.pop_front();
			checked++;
			if (got !== want) begin
				if (failures < 10)
					$display("[%0t] order code mismatch: expected %0d, got %0d",
						$time, want, got);
				failures++;
			end else begin
				seen_codes[want]++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rocmp_in_if #(.VALUE_WIDTH(VW)) op_ch ();
	rocmp_out_if res_ch ();

	rational_order_compare_unit #(.VALUE_WIDTH(VW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (op_ch),
		.result   (res_ch)
	);

	order_tracker tracker = new();
	bit  hold_req;
	int  holds_done;
	int  cycle_count;
	int  items_sent;

	logic signed [VW-1:0] corner_nums [7] = '{NUM_MIN, NUM_MIN + 1, -1, 0, 1,
		NUM_MAX - 1, NUM_MAX};
	logic        [VW-2:0] corner_dens [5] = '{0, 1, 2, DEN_MAX - 1'b1, DEN_MAX};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_operands(logic signed [VW-1:0] ln, logic [VW-2:0] ld,
			logic signed [VW-1:0] rn, logic [VW-2:0] rd, int gap);
		if (gap > 0) begin
			op_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_ch.valid     <= 1'b1;
		op_ch.left_num  <= ln;
		op_ch.left_den  <= ld;
		op_ch.right_num <= rn;
		op_ch.right_den <= rd;
		do @(posedge clk); while (!op_ch.ready);
		items_sent++;
	endtask

	// Note accepted items and check results at the same edge the handshake sees.
	always @(posedge clk) begin
		if (arst_n) begin
			if (op_ch.valid && op_ch.ready)
				tracker.note_operands(op_ch.left_num, op_ch.left_den,
					op_ch.right_num, op_ch.right_den);
			if (res_ch.valid && res_ch.ready)
				tracker.check_order(res_ch.order_code);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, calm stretches, one long hold-off on request.
	initial begin
		int stall_left;
		int sink_cycles;
		int hold_cycles;
		stall_left  = 0;
		sink_cycles = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++)
					@(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				sink_cycles++;
				if (stall_left > 0) begin
					res_ch.ready <= 1'b0;
					stall_left--;
				end else begin
					res_ch.ready <= 1'b1;
					if (((sink_cycles / 500) % 4) != 1 && $urandom_range(0, 99) < 30)
						stall_left = pick_gap();
				end
				@(posedge clk);
			end
		end
	end

	initial begin
		logic signed [VW-1:0] ln, rn, tn;
		logic        [VW-2:0] ld, rd, td;
		int mag, base, k1, k2, kind, gap;

		op_ch.valid     = 1'b0;
		op_ch.left_num  = '0;
		op_ch.left_den  = '0;
		op_ch.right_num = '0;
		op_ch.right_den = '0;
		res_ch.ready    = 1'b0;
		hold_req        = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unnormalized, infinities, zero over zero, field extremes
		send_operands(1, 2, 2, 4, pick_gap());
		send_operands(0, 0, 5, 0, pick_gap());
		send_operands(0, 0, -1, 0, pick_gap());
		send_operands(-7, 0, NUM_MIN, 0, pick_gap());
		send_operands(NUM_MAX, 1, 1, 0, pick_gap());
		send_operands(NUM_MIN, 1, -1, 0, pick_gap());
		send_operands(-3, 0, 0, 5, pick_gap());
		send_operands(NUM_MAX, 1, NUM_MAX, 1, pick_gap());
		send_operands(NUM_MIN, 1, NUM_MAX, 1, pick_gap());
		send_operands(NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX, pick_gap());
		send_operands(NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX - 1'b1, pick_gap());
		send_operands(0, 1, 0, DEN_MAX, pick_gap());
		send_operands(0, 3, -1, DEN_MAX, pick_gap());
		send_operands(1, DEN_MAX, 0, 1, pick_gap());
		send_operands(NUM_MIN, 1, NUM_MIN, 2, pick_gap());
		send_operands(-1, DEN_MAX, -1, DEN_MAX - 1'b1, pick_gap());
		send_operands(NUM_MAX, DEN_MAX, 1, 1, pick_gap());
		send_operands(NUM_MAX - 1, DEN_MAX, 1, 1, pick_gap());
		send_operands(NUM_MIN, DEN_MAX, -1, 1, pick_gap());
		send_operands(5, 0, NUM_MAX, DEN_MAX, pick_gap());
		send_operands(6, 4, 9, 6, pick_gap());
		send_operands(-6, 4, -9, 6, pick_gap());
		send_operands(0, 0, 0, 0, pick_gap());
		send_operands(NUM_MAX - 1, DEN_MAX, NUM_MAX - 2, DEN_MAX - 1'b1, pick_gap());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				ln = $urandom;
				ld = DW'($urandom);
				rn = $urandom;
				rd = DW'($urandom);
			end else if (kind < 35) begin
				// at least one infinite side
				ln = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
				rn = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
				ld = $urandom_range(0, 1) ? '0 : DW'($urandom);
				rd = $urandom_range(0, 1) ? '0 : DW'($urandom);
				if (ld != 0 && rd != 0)
					ld = '0;
			end else if (kind < 60) begin
				// same value, different scaling
				mag  = $urandom_range(0, 30000);
				base = $urandom_range(1, 30000);
				k1   = $urandom_range(1, 60000);
				k2   = $urandom_range(1, 60000);
				if ($urandom_range(0, 1))
					mag = -mag;
				ln = mag * k1;
				ld = DW'(base * k1);
				rn = mag * k2;
				rd = DW'(base * k2);
			end else if (kind < 80) begin
				// neighbors that differ by one step
				if ($urandom_range(0, 1)) begin
					mag  = $urandom_range(0, 60000) - 30000;
					base = $urandom_range(1, 30000);
					k1   = $urandom_range(1, 60000);
					ln   = mag * k1;
					ld   = DW'(base * k1);
				end else begin
					ln = $urandom;
					ld = DW'($urandom);
				end
				rn = ln;
				rd = ld;
				case ($urandom_range(0, 3))
					0: rn = ln + 1;
					1: rn = ln - 1;
					2: rd = ld + 1'b1;
					default: rd = ld - 1'b1;
				endcase
			end else if (kind < 90) begin
				mag = $urandom_range(0, 16);
				ln  = mag - 8;
				mag = $urandom_range(0, 16);
				rn  = mag - 8;
				ld  = DW'($urandom_range(0, 8));
				rd  = DW'($urandom_range(0, 8));
			end else begin
				ln = corner_nums[$urandom_range(0, 6)];
				rn = corner_nums[$urandom_range(0, 6)];
				ld = corner_dens[$urandom_range(0, 4)];
				rd = corner_dens[$urandom_range(0, 4)];
			end
			if ($urandom_range(0, 1)) begin
				tn = ln; ln = rn; rn = tn;
				td = ld; ld = rd; rd = td;
			end
			// back-to-back items while the result side holds off
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n >= HOLD_AT && n < HOLD_AT + 12)
				gap = 0;
			else
				gap = (((n / 150) % 4) == 2) ? 0 : pick_gap();
			send_operands(ln, ld, rn, rd, gap);
		end
		op_ch.valid <= 1'b0;

		while (tracker.pending_orders.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d fraction pairs, %0d with an infinite side; checked %0d results",
			items_sent, tracker.inf_items, tracker.checked);
		$display("Orders less/equal/greater: %0d/%0d/%0d; long result hold-offs: %0d",
			tracker.seen_codes[ORDER_LESS], tracker.seen_codes[ORDER_EQUAL],
			tracker.seen_codes[ORDER_GREATER], holds_done);
		if (tracker.failures == 0 && tracker.pending_orders.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: rational_order_compare_unit.f
rtl/core/rocmp_pkg.sv
rtl/core/rocmp_if.sv
rtl/core/rational_order_compare_unit.sv
tb/sv/tb_rational_order_compare_unit.sv
